### rtl/core/cpiod_pkg.sv
`default_nettype none
package cpiod_pkg;

    localparam int PAD_ALIGN_DEF = 4;

    localparam logic [2:0] MAGIC_LAST     = 3'd5;
    localparam logic [2:0] DIGIT_LAST     = 3'd7;
    localparam logic [3:0] FIELD_FILESIZE = 4'd6;
    localparam logic [3:0] FIELD_NAMESIZE = 4'd11;
    localparam logic [3:0] FIELD_LAST     = 4'd12;
    localparam logic [3:0] TRAILER_LEN    = 4'd11;

    // m_axis_tdata layout
    localparam int TD_IDX_LSB = 0;
    localparam int TD_VAL_LSB = 4;
    localparam int TD_BYTE_LSB = 36;
    localparam int TD_ERR_LSB = 44;
    localparam int TD_WIDTH = 48;

    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_FIELD,
        PH_NAME,
        PH_NAMEPAD,
        PH_DATA,
        PH_DATAPAD,
        PH_DONE,
        PH_ERR_MAGIC,
        PH_ERR_HEX,
        PH_ERR_TRUNC
    } t_phase;

    typedef enum logic [2:0] {
        KIND_FIELD,
        KIND_NAME,
        KIND_DATA,
        KIND_END,
        KIND_ERROR
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_MAGIC,
        ERR_HEX,
        ERR_TRUNC
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  field_index;
        logic [31:0] field_value;
        logic [7:0]  out_byte;
        logic        last;
        t_err        err;
    } t_result;

endpackage
`default_nettype wire

### rtl/core/cpiod_parse.sv
`default_nettype none
module cpiod_parse #(
    parameter int PAD_ALIGN = cpiod_pkg::PAD_ALIGN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_stream_end,
    input  wire logic              i_pass_data,
    output logic                   o_res_valid,
    output cpiod_pkg::t_result     o_res
);
    import cpiod_pkg::*;

    localparam int AW = $clog2(PAD_ALIGN);

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd1, 3'd3: c = "7";
            default:    c = "0";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0: c = "T";
            4'd1: c = "R";
            4'd2: c = "A";
            4'd3: c = "I";
            4'd4: c = "L";
            4'd5: c = "E";
            4'd6: c = "R";
            4'd7, 4'd8, 4'd9: c = "!";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // {ok, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        if (b >= "0" && b <= "9") begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= "a" && b <= "f") begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= "A" && b <= "F") begin
            r = {1'b1, 4'(b - 8'h37)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

    t_phase        r_phase, n_phase;
    logic [AW-1:0] r_align, n_align;
    logic [2:0]    r_digit, n_digit;
    logic [3:0]    r_fnum, n_fnum;
    logic [31:0]   r_acc, n_acc;
    logic [31:0]   r_name_left, n_name_left;
    logic [31:0]   r_data_left, n_data_left;
    logic          r_match, n_match;
    logic [3:0]    r_npos, n_npos;

    logic [4:0]    hex;
    logic [31:0]   acc_next;
    logic          magic_ok;
    logic          name_last;
    logic          data_last;
    logic          match_after;
    logic          trailer_hit;
    logic          own_err;
    logic          active;
    logic [AW-1:0] align_inc;

    always_comb begin
        hex       = hex_decode(i_byte);
        acc_next  = {r_acc[27:0], hex[3:0]};
        if (r_digit == MAGIC_LAST) begin
            magic_ok = (i_byte == "1") || (i_byte == "2");
        end else begin
            magic_ok = (i_byte == magic_char(r_digit));
        end
        name_last   = (r_name_left == 32'd1);
        data_last   = (r_data_left == 32'd1);
        match_after = r_match &&
                      ((r_npos >= TRAILER_LEN) || (i_byte == trailer_char(r_npos)));
        // position reaches the full trailer length on this byte or earlier
        trailer_hit = (r_phase == PH_NAME) && name_last && match_after &&
                      (r_npos >= TRAILER_LEN - 4'd1);
        own_err     = ((r_phase == PH_MAGIC) && !magic_ok) ||
                      ((r_phase == PH_FIELD) && !hex[4]);
        active      = (r_phase != PH_DONE) && (r_phase != PH_ERR_MAGIC) &&
                      (r_phase != PH_ERR_HEX) && (r_phase != PH_ERR_TRUNC);
        align_inc   = (r_align == AW'(PAD_ALIGN - 1)) ? '0 : r_align + AW'(1);
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_align     = r_align;
        n_digit     = r_digit;
        n_fnum      = r_fnum;
        n_acc       = r_acc;
        n_name_left = r_name_left;
        n_data_left = r_data_left;
        n_match     = r_match;
        n_npos      = r_npos;
        if (i_accept && active) begin
            n_align = align_inc;
            unique case (r_phase)
                PH_MAGIC: begin
                    if (!magic_ok) begin
                        n_phase = PH_ERR_MAGIC;
                    end else if (r_digit == MAGIC_LAST) begin
                        n_digit = '0;
                        n_fnum  = '0;
                        n_acc   = '0;
                        n_phase = PH_FIELD;
                    end else begin
                        n_digit = r_digit + 3'd1;
                    end
                end
                PH_FIELD: begin
                    if (!hex[4]) begin
                        n_phase = PH_ERR_HEX;
                    end else if (r_digit == DIGIT_LAST) begin
                        if (r_fnum == FIELD_FILESIZE) n_data_left = acc_next;
                        if (r_fnum == FIELD_NAMESIZE) n_name_left = acc_next;
                        n_digit = '0;
                        n_acc   = '0;
                        if (r_fnum == FIELD_LAST) begin
                            n_fnum  = '0;
                            n_npos  = '0;
                            n_match = 1'b1;
                            if (r_name_left == 32'd0) begin
                                // empty name: straight to padding, data or the next header
                                n_match = 1'b0;
                                if (align_inc != '0) begin
                                    n_phase = PH_NAMEPAD;
                                end else if (r_data_left != 32'd0) begin
                                    n_phase = PH_DATA;
                                end else begin
                                    n_phase = PH_MAGIC;
                                end
                            end else begin
                                n_phase = PH_NAME;
                            end
                        end else begin
                            n_fnum = r_fnum + 4'd1;
                        end
                    end else begin
                        n_acc   = acc_next;
                        n_digit = r_digit + 3'd1;
                    end
                end
                PH_NAME: begin
                    if (r_npos < TRAILER_LEN) begin
                        n_match = match_after;
                        n_npos  = r_npos + 4'd1;
                    end
                    n_name_left = r_name_left - 32'd1;
                    if (trailer_hit) begin
                        n_phase = PH_DONE;
                    end else if (name_last) begin
                        if (align_inc != '0) begin
                            n_phase = PH_NAMEPAD;
                        end else if (r_data_left != 32'd0) begin
                            n_phase = PH_DATA;
                        end else begin
                            n_phase = PH_MAGIC;
                            n_digit = '0;
                        end
                    end
                end
                PH_NAMEPAD: begin
                    if (align_inc == '0) begin
                        if (r_data_left != 32'd0) begin
                            n_phase = PH_DATA;
                        end else begin
                            n_phase = PH_MAGIC;
                            n_digit = '0;
                        end
                    end
                end
                PH_DATA: begin
                    n_data_left = r_data_left - 32'd1;
                    if (data_last) begin
                        if (align_inc != '0) begin
                            n_phase = PH_DATAPAD;
                        end else begin
                            n_phase = PH_MAGIC;
                            n_digit = '0;
                        end
                    end
                end
                PH_DATAPAD: begin
                    if (align_inc == '0) begin
                        n_phase = PH_MAGIC;
                        n_digit = '0;
                    end
                end
                default: ;
            endcase
            if (i_stream_end && !own_err && !trailer_hit) begin
                n_phase = PH_ERR_TRUNC;
            end
        end
    end

    // result
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.kind  = KIND_FIELD;
        o_res.err   = ERR_NONE;
        if (i_accept) begin
            unique case (r_phase)
                PH_ERR_MAGIC: begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                    o_res.err   = ERR_MAGIC;
                end
                PH_ERR_HEX: begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                    o_res.err   = ERR_HEX;
                end
                PH_ERR_TRUNC: begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                    o_res.err   = ERR_TRUNC;
                end
                PH_MAGIC: begin
                    if (!magic_ok) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_ERROR;
                        o_res.err   = ERR_MAGIC;
                    end
                end
                PH_FIELD: begin
                    if (!hex[4]) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_ERROR;
                        o_res.err   = ERR_HEX;
                    end else if (r_digit == DIGIT_LAST) begin
                        o_res_valid       = 1'b1;
                        o_res.kind        = KIND_FIELD;
                        o_res.field_index = r_fnum;
                        o_res.field_value = acc_next;
                    end
                end
                PH_NAME: begin
                    o_res_valid = 1'b1;
                    if (trailer_hit) begin
                        o_res.kind = KIND_END;
                    end else begin
                        o_res.kind     = KIND_NAME;
                        o_res.out_byte = i_byte;
                        o_res.last     = name_last;
                    end
                end
                PH_DATA: begin
                    if (i_pass_data) begin
                        o_res_valid    = 1'b1;
                        o_res.kind     = KIND_DATA;
                        o_res.out_byte = i_byte;
                        o_res.last     = data_last;
                    end
                end
                default: ;
            endcase
            if (active && i_stream_end && !own_err && !trailer_hit) begin
                o_res_valid = 1'b1;
                o_res       = '0;
                o_res.kind  = KIND_ERROR;
                o_res.err   = ERR_TRUNC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC;
            r_align     <= '0;
            r_digit     <= '0;
            r_fnum      <= '0;
            r_acc       <= '0;
            r_name_left <= '0;
            r_data_left <= '0;
            r_match     <= 1'b1;
            r_npos      <= '0;
        end else begin
            r_phase     <= n_phase;
            r_align     <= n_align;
            r_digit     <= n_digit;
            r_fnum      <= n_fnum;
            r_acc       <= n_acc;
            r_name_left <= n_name_left;
            r_data_left <= n_data_left;
            r_match     <= n_match;
            r_npos      <= n_npos;
        end
    end

endmodule
`default_nettype wire

### rtl/core/cpiod_outreg.sv
`default_nettype none
module cpiod_outreg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire cpiod_pkg::t_result i_res,
    output logic                    o_free,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output cpiod_pkg::t_result      o_res
);
    import cpiod_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or being drained this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

### rtl/core/cpio_newc_stream_deframer.sv
`default_nettype none
// cpio newc/crc archive deframer. One archive byte per item on s_axis; each
// item is parsed combinationally and any result (header field value, name
// byte, data byte, archive end or sticky error) lands in one output register.
// An item is taken every clock cycle while the output register is empty or
// being drained, so throughput is one byte per cycle.
// Data bytes are dropped when pass_data is 0. Errors repeat on every later
// item until reset; bytes after archive end produce nothing.
module cpio_newc_stream_deframer #(
    parameter int PAD_ALIGN = cpiod_pkg::PAD_ALIGN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,     // pass_data
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    input  wire logic        s_axis_tlast,   // stream_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // field_index[3:0], field_value[35:4], out_byte[43:36], error_code[45:44]
    output logic [cpiod_pkg::TD_WIDTH-1:0] m_axis_tdata,
    output logic [2:0]       m_axis_tuser,   // item_kind
    output logic             m_axis_tlast    // last_of_run
);
    import cpiod_pkg::*;

    logic    r_pass_data;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    free;
    logic    accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = free;
    assign accept        = s_axis_tvalid && free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_data <= 1'b1;
        end else if (i_cfg_valid) begin
            r_pass_data <= i_cfg_data;
        end
    end

    cpiod_parse #(
        .PAD_ALIGN (PAD_ALIGN)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (s_axis_tdata),
        .i_stream_end (s_axis_tlast),
        .i_pass_data  (r_pass_data),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    cpiod_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {2'b00, out_res.err, out_res.out_byte,
                           out_res.field_value, out_res.field_index};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule
`default_nettype wire

### rtl/core/cpiod_chk.sv
`default_nettype none
module cpiod_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [cpiod_pkg::TD_WIDTH-1:0] m_axis_tdata,
    input wire logic [2:0]                    m_axis_tuser,
    input wire logic                          m_axis_tlast
);
    import cpiod_pkg::*;

    logic [1:0] err_code;
    assign err_code = m_axis_tdata[TD_ERR_LSB +: 2];

    // stalled output item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tuser == KIND_ERROR) == (err_code != ERR_NONE)))
        else $error("error code does not match item kind");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tuser == KIND_NAME) || (m_axis_tuser == KIND_DATA))
        else $error("tlast on item that is neither name nor data");

    // once an error goes out, nothing else follows until reset
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && (m_axis_tuser == KIND_ERROR) |=>
            !m_axis_tvalid || (m_axis_tuser == KIND_ERROR))
        else $error("non-error item after an error");

endmodule

bind cpio_newc_stream_deframer cpiod_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
